// File: hdl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for the memory test sequencer
// Operation codes, register indexes, test selections and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int DEF_ADDR_WIDTH = 32;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int CFG_IDX_W = 2;
    localparam int TDATA_OUT_W = 104;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_TEST_SELECT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd3;

    // result operation codes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_VERDICT = 2'd2;

    // input item kind
    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_RESPONSE = 1'b1;

    // test selections
    localparam logic [2:0] TS_DATA_ONE  = 3'd0;
    localparam logic [2:0] TS_DATA_ZERO = 3'd1;
    localparam logic [2:0] TS_ADDR_ONE  = 3'd2;
    localparam logic [2:0] TS_ADDR_ZERO = 3'd3;
    localparam logic [2:0] TS_ACCESS    = 3'd4;

    // bus width codes
    localparam logic [1:0] BW_8      = 2'd0;
    localparam logic [1:0] BW_16     = 2'd1;
    localparam logic [1:0] BW_32     = 2'd2;
    localparam logic [1:0] BW_UNUSED = 2'd3;

    localparam logic [31:0] MARK_WORD = 32'h5555_5555;
    localparam logic [31:0] FILL_WORD = 32'hAAAA_AAAA;

    localparam logic [2:0]  RST_TEST_SELECT  = TS_DATA_ONE;
    localparam logic [1:0]  RST_BUS_WIDTH    = BW_32;
    localparam logic [4:0]  RST_SIZE_LOG2    = 5'd16;
    localparam logic [31:0] RST_BASE_ADDRESS = 32'd0;

    typedef struct packed {
        logic [2:0]  test_select;
        logic [1:0]  bus_width;
        logic [4:0]  size_log2;
        logic [31:0] base_address;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
        logic [31:0] write_data;
        logic        passed;
        logic [31:0] fail_code;
        logic        last;
    } result_t;

    // byte address of a word index
    function automatic logic [31:0] word_addr(input logic [31:0] base,
                                              input logic [31:0] idx,
                                              input logic [1:0]  wlog);
        word_addr = base + (idx << wlog);
    endfunction

endpackage : mts_pkg

`default_nettype wire

// File: hdl/mts_cfg_regs.sv
// ----------------------------------------------------------------------------
// mts_cfg_regs: configuration register file
// Holds test selection, bus width, memory size and base address.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_cfg_regs
    import mts_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.test_select  <= RST_TEST_SELECT;
            cfg_reg.bus_width    <= RST_BUS_WIDTH;
            cfg_reg.size_log2    <= RST_SIZE_LOG2;
            cfg_reg.base_address <= RST_BASE_ADDRESS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEST_SELECT:  cfg_reg.test_select  <= cfg_data[2:0];
                REG_BUS_WIDTH:    cfg_reg.bus_width    <= cfg_data[1:0];
                REG_SIZE_LOG2:    cfg_reg.size_log2    <= cfg_data[4:0];
                REG_BASE_ADDRESS: cfg_reg.base_address <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

endmodule : mts_cfg_regs

`default_nettype wire

// File: hdl/mts_in_reg.sv
// ----------------------------------------------------------------------------
// mts_in_reg: input register
// Captures one input transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_in_reg
    import mts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        advance,
    output logic             item_valid,
    output logic             item_mode,
    output logic [31:0]      item_read_data
);

    logic        valid_reg;
    logic        mode_reg;
    logic [31:0] rd_reg;

    // free when empty or when the held item moves on this cycle
    assign s_tready       = !valid_reg || advance;
    assign item_valid     = valid_reg;
    assign item_mode      = mode_reg;
    assign item_read_data = rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg <= s_tuser;
            rd_reg   <= s_tdata;
        end
    end

endmodule : mts_in_reg

`default_nettype wire

// File: hdl/mts_core.sv
// ----------------------------------------------------------------------------
// mts_core: test sequencer state and next-operation logic
// Holds the test state and turns each item into the next write, read or verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_core
    import mts_pkg::*;
#(
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic        mode,
    input  wire logic [31:0] read_data,
    input  wire cfg_t        cfg,
    output logic             has_result,
    output result_t          result
);

    localparam logic [31:0] A_MASK = 32'hFFFF_FFFF >> (32 - ADDR_WIDTH);
    localparam logic [31:0] D_MASK = 32'hFFFF_FFFF >> (32 - DATA_WIDTH);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_DW_ACK  = 3'd1;
    localparam logic [2:0] PH_DW_DATA = 3'd2;
    localparam logic [2:0] PH_AW_MARK = 3'd3;
    localparam logic [2:0] PH_AW_VAL  = 3'd4;
    localparam logic [2:0] PH_AW_DATA = 3'd5;
    localparam logic [2:0] PH_AC      = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] wp_reg, wp_next;
    logic [4:0]  ws_reg, ws_next;
    logic [30:0] ei_reg, ei_next;
    logic [1:0]  sw_reg, sw_next;

    // geometry
    logic [1:0]  wlog;
    logic [31:0] dmask;
    logic [31:0] wcount;
    logic [31:0] wc_m1;
    logic [29:0] ac_dim;
    logic        has_win;
    logic [4:0]  last_shift;
    logic [31:0] rd_m;

    // access test stepping
    logic [31:0] ei_inc;
    logic        wrap;
    logic        sweep_done;
    logic [30:0] ei_adv;
    logic [1:0]  sw_adv;
    logic [4:0]  ws_adv;
    logic        ac_end;
    logic [31:0] ac_cur_val;
    logic [31:0] ac_adv_v;
    logic [31:0] ac_adv_val;
    logic [31:0] ac_idx;

    // walks
    logic [31:0] dw_cur_val;
    logic [31:0] wp_shl;
    logic [32:0] aw_next;
    logic [31:0] mark_idx;
    logic [31:0] mark_m;

    // result fields before address formation
    logic [1:0]  r_op;
    logic [31:0] r_idx;
    logic [31:0] r_wdata;
    logic        r_pass;
    logic [31:0] r_code;

    always_comb
    begin
        case (cfg.bus_width)
            BW_8:    wlog = 2'd0;
            BW_16:   wlog = 2'd1;
            default: wlog = 2'd2;
        endcase
        case (cfg.bus_width)
            BW_8:    dmask = 32'h0000_00FF & D_MASK;
            BW_16:   dmask = 32'h0000_FFFF & D_MASK;
            default: dmask = D_MASK;
        endcase

        if (cfg.size_log2 < {3'd0, wlog})
            wcount = 32'd1;
        else
            wcount = 32'd1 << (cfg.size_log2 - {3'd0, wlog});
        wc_m1 = wcount - 32'd1;

        case (cfg.bus_width)
            BW_8:
            begin
                ac_dim     = 30'd256;
                has_win    = (cfg.size_log2 >= 5'd8);
                last_shift = cfg.size_log2 - 5'd8;
            end
            BW_16:
            begin
                ac_dim     = 30'd32768;
                has_win    = (cfg.size_log2 >= 5'd16);
                last_shift = cfg.size_log2 - 5'd16;
            end
            default:
            begin
                ac_dim     = (cfg.size_log2 < 5'd2) ? 30'd0
                                                    : 30'd1 << (cfg.size_log2 - 5'd2);
                has_win    = (cfg.size_log2 >= 5'd2);
                last_shift = 5'd0;
            end
        endcase

        rd_m = read_data & dmask;
    end

    // access test: next index, pass and window
    always_comb
    begin
        ei_inc     = {1'b0, ei_reg} + 32'd1;
        wrap       = (ei_inc >= {2'd0, ac_dim});
        sweep_done = wrap && (sw_reg == 2'd3);
        ei_adv     = wrap ? '0 : ei_inc[30:0];
        sw_adv     = wrap ? sw_reg + 2'd1 : sw_reg;
        ws_adv     = sweep_done ? ws_reg + 5'd1 : ws_reg;
        ac_end     = !has_win || (sweep_done && (ws_adv == 5'd0)) || (ws_adv > last_shift);

        ac_cur_val = (sw_reg[1] ? ~ei_inc : ei_inc) & dmask;
        ac_adv_v   = {1'b0, ei_adv} + 32'd1;
        ac_adv_val = (sw_adv[1] ? ~ac_adv_v : ac_adv_v) & dmask;
        ac_idx     = {1'b0, ei_adv} << ws_adv;
    end

    // walks
    always_comb
    begin
        dw_cur_val = (sw_reg[0] ? ~wp_reg : wp_reg) & dmask;
        wp_shl     = wp_reg << 1;
        aw_next    = {1'b0, wp_reg} << 1;
        mark_idx   = sw_reg[0] ? wc_m1 : 32'd0;
        mark_m     = MARK_WORD & dmask;
    end

    always_comb
    begin
        phase_next = phase_reg;
        wp_next    = wp_reg;
        ws_next    = ws_reg;
        ei_next    = ei_reg;
        sw_next    = sw_reg;
        has_result = 1'b0;
        r_op       = OP_VERDICT;
        r_idx      = 32'd0;
        r_wdata    = 32'd0;
        r_pass     = 1'b0;
        r_code     = 32'd0;

        if (mode == MODE_START)
        begin
            has_result = 1'b1;
            wp_next    = 32'd1;
            ws_next    = 5'd0;
            ei_next    = '0;
            sw_next    = 2'd0;
            phase_next = PH_IDLE;
            if (cfg.bus_width == BW_UNUSED || cfg.test_select > TS_ACCESS)
            begin
                r_code = 32'hFFFF_FFFF;
            end
            else if (cfg.test_select inside {TS_DATA_ONE, TS_DATA_ZERO})
            begin
                sw_next    = {1'b0, cfg.test_select[0]};
                phase_next = PH_DW_ACK;
                r_op       = OP_WRITE;
                r_wdata    = (cfg.test_select[0] ? ~32'd1 : 32'd1) & dmask;
            end
            else if (cfg.test_select inside {TS_ADDR_ONE, TS_ADDR_ZERO})
            begin
                sw_next    = {1'b0, cfg.test_select[0]};
                phase_next = PH_AW_MARK;
                r_op       = OP_WRITE;
                r_idx      = cfg.test_select[0] ? wc_m1 : 32'd0;
                r_wdata    = mark_m;
            end
            else if (!has_win)
            begin
                r_pass = 1'b1;
            end
            else
            begin
                phase_next = PH_AC;
                r_op       = OP_WRITE;
                r_wdata    = 32'd1 & dmask;
            end
        end
        else
        begin
            case (phase_reg)
                PH_DW_ACK:
                begin
                    has_result = 1'b1;
                    phase_next = PH_DW_DATA;
                    r_op       = OP_READ;
                end
                PH_DW_DATA:
                begin
                    has_result = 1'b1;
                    phase_next = PH_IDLE;
                    if (rd_m != dw_cur_val)
                        r_code = wp_reg;
                    else if ((wp_shl & dmask) == 32'd0)
                        r_pass = 1'b1;
                    else
                    begin
                        wp_next    = wp_shl;
                        phase_next = PH_DW_ACK;
                        r_op       = OP_WRITE;
                        r_wdata    = (sw_reg[0] ? ~wp_shl : wp_shl) & dmask;
                    end
                end
                PH_AW_MARK:
                begin
                    has_result = 1'b1;
                    if (wp_reg >= wcount)
                    begin
                        phase_next = PH_IDLE;
                        r_pass     = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_AW_VAL;
                        r_op       = OP_WRITE;
                        r_idx      = sw_reg[0] ? (~wp_reg & wc_m1) : wp_reg;
                        r_wdata    = FILL_WORD & dmask;
                    end
                end
                PH_AW_VAL:
                begin
                    has_result = 1'b1;
                    phase_next = PH_AW_DATA;
                    r_op       = OP_READ;
                    r_idx      = mark_idx;
                end
                PH_AW_DATA:
                begin
                    has_result = 1'b1;
                    phase_next = PH_IDLE;
                    if (rd_m != mark_m)
                        r_code = wp_reg;
                    else if (aw_next >= {1'b0, wcount})
                        r_pass = 1'b1;
                    else
                    begin
                        wp_next    = aw_next[31:0];
                        phase_next = PH_AW_VAL;
                        r_op       = OP_WRITE;
                        r_idx      = sw_reg[0] ? (~aw_next[31:0] & wc_m1) : aw_next[31:0];
                        r_wdata    = FILL_WORD & dmask;
                    end
                end
                PH_AC:
                begin
                    has_result = 1'b1;
                    if (sw_reg[0] && (rd_m != ac_cur_val))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (ac_end)
                    begin
                        phase_next = PH_IDLE;
                        r_pass     = 1'b1;
                    end
                    else
                    begin
                        ei_next = ei_adv;
                        sw_next = sw_adv;
                        ws_next = ws_adv;
                        r_idx   = ac_idx;
                        if (sw_adv[0])
                            r_op = OP_READ;
                        else
                        begin
                            r_op    = OP_WRITE;
                            r_wdata = ac_adv_val;
                        end
                    end
                end
                default:
                begin
                    has_result = 1'b0;
                end
            endcase
        end

        result.op         = r_op;
        result.address    = (r_op == OP_VERDICT) ? 32'd0
                          : word_addr(cfg.base_address, r_idx, wlog) & A_MASK;
        result.write_data = r_wdata;
        result.passed     = r_pass;
        result.fail_code  = r_code;
        result.last       = (r_op == OP_VERDICT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wp_reg    <= 32'd1;
            ws_reg    <= 5'd0;
            ei_reg    <= '0;
            sw_reg    <= 2'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            ws_reg    <= ws_next;
            ei_reg    <= ei_next;
            sw_reg    <= sw_next;
        end
    end

endmodule : mts_core

`default_nettype wire

// File: hdl/memory_test_sequencer.sv
// Path: an accepted input transaction is held in the input register, and its result
// is then held in the result register until m_tready takes it.
// Throughput: one input transaction per cycle while the result register is empty or
// being taken; the next test state in mts_core is combinational from its registers.
// Reset: configuration returns to test 0, 32-bit bus, 64 KiB, base 0; the sequencer
// is idle and both registers are empty.
// ----------------------------------------------------------------------------
// memory_test_sequencer: walking-bit and access memory test engine
// Turns start and response transactions into memory writes, reads and verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_test_sequencer
    import mts_pkg::*;
#(
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,   // read_data
    input  wire logic [0:0]             s_tuser,   // mode
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // address [31:0], write_data [63:32], passed [64], fail_code [96:65], zero pad
    output logic [TDATA_OUT_W-1:0]      m_tdata,
    output logic [1:0]                  m_tuser,   // op
    output logic                        m_tlast
);

    cfg_t        cfg;
    logic        item_valid;
    logic        item_mode;
    logic [31:0] item_rd;
    logic        advance;
    logic        has_result;
    result_t     core_result;

    logic        out_valid_reg;
    result_t     out_reg;

    assign advance = item_valid && (!out_valid_reg || m_tready);

    mts_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mts_in_reg u_in
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser[0]),
        .advance        (advance),
        .item_valid     (item_valid),
        .item_mode      (item_mode),
        .item_read_data (item_rd)
    );

    mts_core #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .mode       (item_mode),
        .read_data  (item_rd),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.op;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.fail_code, out_reg.passed,
                       out_reg.write_data, out_reg.address};

    // an empty result register never stalls the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // a new result only follows an item that moved into the core
    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(advance))
        else $error("result appeared without an item");

    // a passing verdict carries no fail code and ends the test
    a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.passed) |->
            (out_reg.op == OP_VERDICT && out_reg.fail_code == 32'd0 && m_tlast))
        else $error("malformed passing verdict");

endmodule : memory_test_sequencer

`default_nettype wire
